FILE: hdl/bqf_pkg.sv
package bqf_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF   = 32;

   localparam int NUM_COEFS   = 5;
   localparam int COEF_IDX_W  = 3;
   localparam int COEF_FRAC_HEAD = 3;

   localparam logic [COEF_IDX_W-1:0] COEF_B0 = 3'd0;
   localparam logic [COEF_IDX_W-1:0] COEF_B1 = 3'd1;
   localparam logic [COEF_IDX_W-1:0] COEF_B2 = 3'd2;
   localparam logic [COEF_IDX_W-1:0] COEF_A1 = 3'd3;
   localparam logic [COEF_IDX_W-1:0] COEF_A2 = 3'd4;

   // control of one serial shift-add lane
   typedef struct packed {
      logic clear;
      logic step;
      logic mult_bit;
      logic subtract;
   } mac_ctrl_type;

endpackage

FILE: hdl/biquad_iir_filter.sv
// channel | dir | handshake             | tdata              | tuser
// req     | in  | req_tvalid/req_tready | sample_in          | clear_state
// rsp     | out | rsp_tvalid/rsp_tready | sample_out         | clipped
// csr     | in  | csr_wr_en             | csr_wdata @ csr_index (0..4: b0 b1 b2 a1 a2)
//
// One sample is worked through by the shift-add lanes: one multiplier
// bit per cycle, first over x, then over y.
// Reset (synchronous) zeroes both delays and loads b0 = 1.0, others 0.
// A new sample is taken while the previous result still waits on rsp.
// Completion holds in the last step while the output register is full.
module biquad_iir_filter #(
   parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF,
   localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [TDATA_W-1:0]                req_tdata,   // sample_in
   input  logic [0:0]                        req_tuser,   // clear_state
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [TDATA_W-1:0]                rsp_tdata,   // sample_out
   output logic [0:0]                        rsp_tuser,   // clipped
   input  logic                              csr_wr_en,
   input  logic [bqf_pkg::COEF_IDX_W-1:0]    csr_index,
   input  logic [COEF_WIDTH-1:0]             csr_wdata
);

   localparam int DW    = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int AW    = DW + 2;
   localparam int FRAC  = COEF_WIDTH - bqf_pkg::COEF_FRAC_HEAD;
   localparam int YW    = AW - FRAC;
   localparam int CNT_W = $clog2(SAMPLE_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_WIDTH - 1);
   localparam logic [AW-1:0] RND_HALF =
      {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL_X  = 6'b000010,
      ST_ROUND1 = 6'b000100,
      ST_ROUND2 = 6'b001000,
      ST_MUL_Y  = 6'b010000,
      ST_SUM    = 6'b100000
   } state_type;

   // ST_SUM covers two steps, told apart by sum_phase_ff
   state_type                state_ff, state_in;
   logic                     sum_phase_ff, sum_phase_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SAMPLE_WIDTH-1:0]  x_sh_ff, x_sh_in;
   logic [SAMPLE_WIDTH-1:0]  y_sh_ff, y_sh_in;
   logic [SAMPLE_WIDTH-1:0]  y_ff, y_in;
   logic                     clip_ff, clip_in;
   logic [DW-1:0]            d1_ff, d1_in;
   logic [DW-1:0]            d2_ff, d2_in;
   logic [AW-1:0]            sum_ff, sum_in;
   logic [AW-1:0]            n2_ff, n2_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]  rsp_y_ff, rsp_y_in;
   logic                     rsp_clip_ff, rsp_clip_in;

   logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs;
   bqf_pkg::mac_ctrl_type    ctrl0, ctrl1, ctrl2, ctrl3;
   logic [COEF_WIDTH-1:0]    coef0;
   logic [AW-1:0]            acc0, acc1, acc2, acc3;

   logic                     req_xfer;
   logic                     commit;
   logic                     cnt_last;
   logic [AW-1:0]            rounded;
   logic [YW-1:0]            y_full;
   logic [AW-1:0]            n1;

   function automatic logic [DW-1:0] sat_delay(input logic [AW-1:0] v);
      logic [AW-DW:0] top;
      top = v[AW-1:DW-1];
      if ((&top) || !(|top)) begin
         return v[DW-1:0];
      end
      return v[AW-1] ? D_MIN : D_MAX;
   endfunction

   bqf_coef_bank #(.COEF_WIDTH(COEF_WIDTH)) u_coef_bank (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .coefs    (coefs)
   );

   // lane 0: b0*x, then -a1*y; lanes 1, 2: b1*x, b2*x; lane 3: -a2*y
   bqf_serial_mac #(.COEF_WIDTH(COEF_WIDTH), .ACC_WIDTH(AW)) u_mac0 (
      .clock (clock), .ctrl (ctrl0), .coef (coef0), .acc (acc0)
   );
   bqf_serial_mac #(.COEF_WIDTH(COEF_WIDTH), .ACC_WIDTH(AW)) u_mac1 (
      .clock (clock), .ctrl (ctrl1), .coef (coefs[1]), .acc (acc1)
   );
   bqf_serial_mac #(.COEF_WIDTH(COEF_WIDTH), .ACC_WIDTH(AW)) u_mac2 (
      .clock (clock), .ctrl (ctrl2), .coef (coefs[2]), .acc (acc2)
   );
   bqf_serial_mac #(.COEF_WIDTH(COEF_WIDTH), .ACC_WIDTH(AW)) u_mac3 (
      .clock (clock), .ctrl (ctrl3), .coef (coefs[4]), .acc (acc3)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign cnt_last   = (cnt_ff == CNT_LAST);
   assign commit     = (state_ff == ST_SUM) && sum_phase_ff
                       && (!rsp_valid_ff || rsp_tready);
   assign coef0      = (state_ff == ST_MUL_Y) ? coefs[3] : coefs[0];

   always_comb begin
      ctrl0.clear    = req_xfer || (state_ff == ST_ROUND2);
      ctrl0.step     = (state_ff == ST_MUL_X) || (state_ff == ST_MUL_Y);
      ctrl0.mult_bit = (state_ff == ST_MUL_Y) ? y_sh_ff[SAMPLE_WIDTH-1]
                                              : x_sh_ff[SAMPLE_WIDTH-1];
      ctrl0.subtract = (state_ff == ST_MUL_Y) ? (cnt_ff != '0) : (cnt_ff == '0);

      ctrl1.clear    = req_xfer;
      ctrl1.step     = (state_ff == ST_MUL_X);
      ctrl1.mult_bit = x_sh_ff[SAMPLE_WIDTH-1];
      ctrl1.subtract = (cnt_ff == '0);
      ctrl2          = ctrl1;

      ctrl3.clear    = (state_ff == ST_ROUND2);
      ctrl3.step     = (state_ff == ST_MUL_Y);
      ctrl3.mult_bit = y_sh_ff[SAMPLE_WIDTH-1];
      ctrl3.subtract = (cnt_ff != '0);
   end

   always_comb begin
      rounded = sum_ff + RND_HALF;
      y_full  = rounded[AW-1:FRAC];
      n1      = sum_ff + {{(AW-DW){d2_ff[DW-1]}}, d2_ff};
   end

   always_comb begin
      state_in     = state_ff;
      sum_phase_in = sum_phase_ff;
      cnt_in       = cnt_ff;
      x_sh_in      = x_sh_ff;
      y_sh_in      = y_sh_ff;
      y_in         = y_ff;
      clip_in      = clip_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      sum_in       = sum_ff;
      n2_in        = n2_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_clip_in  = rsp_clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_sh_in  = req_tdata[SAMPLE_WIDTH-1:0];
               cnt_in   = '0;
               state_in = ST_MUL_X;
               if (req_tuser[0]) begin
                  d1_in = '0;
                  d2_in = '0;
               end
            end
         end
         ST_MUL_X: begin
            x_sh_in = {x_sh_ff[SAMPLE_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_ROUND1;
            end
         end
         ST_ROUND1: begin
            sum_in   = acc0 + {{(AW-DW){d1_ff[DW-1]}}, d1_ff};
            state_in = ST_ROUND2;
         end
         ST_ROUND2: begin
            if ((&y_full[YW-1:SAMPLE_WIDTH-1]) || !(|y_full[YW-1:SAMPLE_WIDTH-1])) begin
               y_in    = y_full[SAMPLE_WIDTH-1:0];
               clip_in = 1'b0;
            end else begin
               y_in    = y_full[YW-1] ? Y_MIN : Y_MAX;
               clip_in = 1'b1;
            end
            y_sh_in  = y_in;
            cnt_in   = '0;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            y_sh_in = {y_sh_ff[SAMPLE_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in       = '0;
               sum_phase_in = 1'b0;
               state_in     = ST_SUM;
            end
         end
         ST_SUM: begin
            if (!sum_phase_ff) begin
               sum_in       = acc1 + acc0;
               n2_in        = acc2 + acc3;
               sum_phase_in = 1'b1;
            end else if (commit) begin
               d1_in        = sat_delay(n1);
               d2_in        = sat_delay(n2_ff);
               rsp_y_in     = y_ff;
               rsp_clip_in  = clip_ff;
               rsp_valid_in = 1'b1;
               sum_phase_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_phase_ff <= 1'b0;
         cnt_ff       <= '0;
         d1_ff        <= '0;
         d2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_phase_ff <= sum_phase_in;
         cnt_ff       <= cnt_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_sh_ff     <= x_sh_in;
      y_sh_ff     <= y_sh_in;
      y_ff        <= y_in;
      clip_ff     <= clip_in;
      sum_ff      <= sum_in;
      n2_ff       <= n2_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_y_ff);
   assign rsp_tuser  = rsp_clip_ff;

`ifndef SYNTH
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_SUM))
      else $error("result raised outside the final step");

   a_round_after_last_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND1) |-> ($past(cnt_ff) == CNT_LAST))
      else $error("rounding entered before all sample bits were used");

   a_feedforward_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_Y) && $past(state_ff == ST_MUL_Y)
      |-> $stable(acc1) && $stable(acc2))
      else $error("feedforward lanes changed during feedback pass");

   a_clip_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0]
      |-> (rsp_y_ff == Y_MAX) || (rsp_y_ff == Y_MIN))
      else $error("clip flag set on an unsaturated sample");
`endif

endmodule

FILE: hdl/bqf_coef_bank.sv
module bqf_coef_bank #(
   parameter int COEF_WIDTH = bqf_pkg::COEF_WIDTH_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           wr_en,
   input  logic [bqf_pkg::COEF_IDX_W-1:0]                 wr_index,
   input  logic [COEF_WIDTH-1:0]                          wr_data,
   output logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0]  coefs
);

   localparam logic [COEF_WIDTH-1:0] UNITY =
      {3'b001, {(COEF_WIDTH-bqf_pkg::COEF_FRAC_HEAD){1'b0}}};
   localparam logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] RESET_COEFS =
      {{((bqf_pkg::NUM_COEFS-1)*COEF_WIDTH){1'b0}}, UNITY};

   logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs_ff;
   logic [bqf_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs_in;

   always_comb begin
      coefs_in = coefs_ff;
      if (wr_en) begin
         unique case (wr_index)
            bqf_pkg::COEF_B0: coefs_in[0] = wr_data;
            bqf_pkg::COEF_B1: coefs_in[1] = wr_data;
            bqf_pkg::COEF_B2: coefs_in[2] = wr_data;
            bqf_pkg::COEF_A1: coefs_in[3] = wr_data;
            bqf_pkg::COEF_A2: coefs_in[4] = wr_data;
            default: coefs_in = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= RESET_COEFS;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

FILE: hdl/bqf_serial_mac.sv
module bqf_serial_mac #(
   parameter int COEF_WIDTH = bqf_pkg::COEF_WIDTH_DEF,
   parameter int ACC_WIDTH  = bqf_pkg::SAMPLE_WIDTH_DEF + bqf_pkg::COEF_WIDTH_DEF + 2
) (
   input  logic                   clock,
   input  bqf_pkg::mac_ctrl_type  ctrl,
   input  logic [COEF_WIDTH-1:0]  coef,
   output logic [ACC_WIDTH-1:0]   acc
);

   // multiplier bits arrive msb first: acc = 2*acc +/- bit*coef
   logic [ACC_WIDTH-1:0] acc_ff;
   logic [ACC_WIDTH-1:0] acc_in;
   logic [ACC_WIDTH-1:0] coef_ext;
   logic [ACC_WIDTH-1:0] doubled;
   logic [ACC_WIDTH-1:0] term;

   always_comb begin
      coef_ext = {{(ACC_WIDTH-COEF_WIDTH){coef[COEF_WIDTH-1]}}, coef};
      doubled  = {acc_ff[ACC_WIDTH-2:0], 1'b0};
      term     = ctrl.mult_bit ? coef_ext : '0;
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.step) begin
         acc_in = ctrl.subtract ? (doubled - term) : (doubled + term);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
